FILE: rtl/core/sss_pkg.sv
// Shared types, widths and codes for the server selection scheduler.
package sss_pkg;

  localparam int unsigned MaxServersDef = 16;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned CntW   = 5;
  localparam int unsigned SrvW   = 5;
  localparam int unsigned TagW   = 16;
  localparam int unsigned WIdxW  = 4;
  localparam int unsigned WValW  = 8;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned RegW     = 32;

  typedef enum logic [ModeW-1:0] {
    PolRoundRobin = 3'd1,
    PolSweep      = 3'd2,
    PolOddEven    = 3'd3,
    PolWeighted   = 3'd4
  } policy_e;

  typedef enum logic {
    OpRequest = 1'b0,
    OpLoad    = 1'b1
  } op_e;

  typedef enum logic {
    RegPolicy = 1'b0,
    RegCount  = 1'b1
  } reg_e;

  typedef struct packed {
    logic            hit;
    logic [SrvW-1:0] server;
  } sss_res_t;

endpackage

FILE: rtl/core/sss_sched.sv
// Pointer, sweep phase and weight tables with the per-beat selection logic.
module sss_sched #(
  parameter int unsigned MaxServers = sss_pkg::MaxServersDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_i,
  input  logic                      load_i,
  input  logic [sss_pkg::WIdxW-1:0] weight_index_i,
  input  logic [sss_pkg::WValW-1:0] weight_value_i,
  input  logic [sss_pkg::ModeW-1:0] mode_i,
  input  logic [sss_pkg::CntW-1:0]  count_i,
  output sss_pkg::sss_res_t         res_o
);
  import sss_pkg::*;

  localparam int unsigned CntMax = (1 << CntW) - 1;
  localparam int unsigned Depth  = (MaxServers < CntMax) ? MaxServers : CntMax;
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;

  logic [SrvW-1:0]  ptr_q, ptr_d;
  logic             phase_q, phase_d;
  logic [WValW-1:0] rem_q  [Depth];
  logic [WValW-1:0] orig_q [Depth];

  logic [SrvW-1:0]  n;
  logic [SrvW-1:0]  cur;
  logic [SrvW-1:0]  k;
  logic [IdxW-1:0]  kidx;
  logic [WValW-1:0] rem_rd, orig_rd, w_dec, w_new;
  logic             mode_ok, hit, at_top, near_top, wt_we;
  logic [WValW-1:0] wv;

  always_comb begin
    n = SrvW'(count_i);
    if (n == '0) begin
      n = SrvW'(1);
    end
    if (n > SrvW'(Depth)) begin
      n = SrvW'(Depth);
    end
  end

  assign cur  = (ptr_q == '0 || ptr_q > n) ? SrvW'(1) : ptr_q;
  assign k    = cur - SrvW'(1);
  assign kidx = k[IdxW-1:0];

  assign rem_rd  = rem_q[kidx];
  assign orig_rd = orig_q[kidx];
  assign w_dec   = (rem_rd == '0) ? '0 : rem_rd - WValW'(1);

  assign mode_ok = (mode_i == PolRoundRobin) || (mode_i == PolSweep) ||
                   (mode_i == PolOddEven) || (mode_i == PolWeighted);
  assign hit      = req_i && mode_ok;
  assign at_top   = (cur >= n);
  assign near_top = ({1'b0, cur} + (SrvW+1)'(2)) > {1'b0, n};

  always_comb begin
    ptr_d   = ptr_q;
    phase_d = phase_q;
    wt_we   = 1'b0;
    w_new   = w_dec;
    if (hit) begin
      ptr_d = cur;
      unique case (mode_i)
        PolRoundRobin: begin
          ptr_d = at_top ? SrvW'(1) : cur + SrvW'(1);
        end
        PolSweep: begin
          if (!phase_q) begin
            if (at_top) begin
              ptr_d   = (n >= SrvW'(2)) ? n - SrvW'(1) : SrvW'(1);
              phase_d = 1'b1;
            end else begin
              ptr_d = cur + SrvW'(1);
            end
          end else begin
            if (cur <= SrvW'(1)) begin
              ptr_d   = (n >= SrvW'(2)) ? SrvW'(2) : SrvW'(1);
              phase_d = 1'b0;
            end else begin
              ptr_d = cur - SrvW'(1);
            end
          end
        end
        PolOddEven: begin
          if (n > SrvW'(1)) begin
            if (near_top) begin
              ptr_d   = phase_q ? SrvW'(1) : SrvW'(2);
              phase_d = ~phase_q;
            end else begin
              ptr_d = cur + SrvW'(2);
            end
          end
        end
        PolWeighted: begin
          wt_we = 1'b1;
          if (w_dec == '0) begin
            w_new = orig_rd;
            ptr_d = at_top ? SrvW'(1) : cur + SrvW'(1);
          end
        end
        default: begin
          ptr_d = ptr_q;
        end
      endcase
    end
  end

  assign wv = (weight_value_i == '0) ? WValW'(1) : weight_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= SrvW'(1);
      phase_q <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        rem_q[i]  <= WValW'(1);
        orig_q[i] <= WValW'(1);
      end
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (load_i && 32'(weight_index_i) == i) begin
          rem_q[i]  <= wv;
          orig_q[i] <= wv;
        end else if (wt_we && 32'(k) == i) begin
          rem_q[i] <= w_new;
        end
      end
    end
  end

  assign res_o.hit    = hit;
  assign res_o.server = cur;

`ifndef ASSERT_OFF
  a_ptr_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q != '0)
    else $error("pointer is zero");

  a_load_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && 32'(weight_index_i) < Depth) |=>
      rem_q[IdxW'($past(weight_index_i))] == orig_q[IdxW'($past(weight_index_i))])
    else $error("loaded weight not mirrored");

  a_rem_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && mode_i == PolWeighted) |-> rem_rd != '0)
    else $error("remaining weight reached zero without reload");
`endif

endmodule

FILE: rtl/core/server_selection_scheduler.sv
// Top level of the server selection scheduler: stream ports, APB registers, result register.
//
// A request picks its server in the cycle it is accepted, from the pointer, sweep phase and one
// weight read-modify-write, and the result appears in the output register on the next cycle;
// the input stays ready while the output register is empty or being drained, so requests and
// weight loads stream at one per cycle. A weight load and a request under an undefined policy
// give no result. The weight tables come out of reset already holding 1, with no start-up sweep.
// The user must write registers only while the block is idle; the block does not enforce it.
module server_selection_scheduler #(
  parameter int unsigned MaxServers = sss_pkg::MaxServersDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] request_tag, [19:16] weight_index, [27:20] weight_value, [31:28] zero
  input  logic [sss_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] op
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [4:0] server_number, [20:5] tag_out, [23:21] zero
  output logic [sss_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sss_pkg::AddrW-1:0]    paddr,
  input  logic [sss_pkg::RegW-1:0]     pwdata,
  output logic [sss_pkg::RegW-1:0]     prdata,
  output logic                         pready
);
  import sss_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic [CntW-1:0]  count_q;
  logic             cfg_we;
  reg_e             reg_sel;

  logic             s_acc, req, load;
  sss_res_t         res;

  logic             out_valid_q, out_valid_d;
  logic [SrvW-1:0]  srv_q;
  logic [TagW-1:0]  tag_q;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeW'(1);
      count_q <= CntW'(1);
    end else if (cfg_we) begin
      unique case (reg_sel)
        RegPolicy: mode_q  <= pwdata[ModeW-1:0];
        RegCount:  count_q <= pwdata[CntW-1:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPolicy: prdata = RegW'(mode_q);
      RegCount:  prdata = RegW'(count_q);
      default:   prdata = '0;
    endcase
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign req           = s_acc && (s_axis_tuser == OpRequest);
  assign load          = s_acc && (s_axis_tuser == OpLoad);

  sss_sched #(
    .MaxServers (MaxServers)
  ) u_sched (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .load_i         (load),
    .weight_index_i (s_axis_tdata[19:16]),
    .weight_value_i (s_axis_tdata[27:20]),
    .mode_i         (mode_q),
    .count_i        (count_q),
    .res_o          (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.hit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.hit) begin
      srv_q <= res.server;
      tag_q <= s_axis_tdata[TagW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW-TagW-SrvW)'(0), tag_q, srv_q};

`ifndef ASSERT_OFF
  a_hit_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.hit |=> out_valid_q)
    else $error("selected request lost");

  a_srv_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (srv_q != '0 && 32'(srv_q) <= MaxServers))
    else $error("server number out of range");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && !m_axis_tready))
    else $error("input stalled with output free");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking stream testbench for the server selection scheduler.
module tb;
  import sss_pkg::*;

  typedef struct {
    op_e              op;
    logic [TagW-1:0]  tag;
    logic [WIdxW-1:0] widx;
    logic [WValW-1:0] wval;
  } job_t;

  typedef struct {
    logic [SrvW-1:0] server;
    logic [TagW-1:0] tag;
  } assignment_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [15:0] request_tag, [19:16] weight_index, [27:20] weight_value, [31:28] zero
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // [0] op
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [4:0] server_number, [20:5] tag_out, [23:21] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [RegW-1:0]     pwdata = '0;
  logic [RegW-1:0]     prdata;
  logic                pready;

  server_selection_scheduler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  job_t        job_q[$];
  assignment_t assignments_q[$];
  job_t        cur_job;
  int unsigned jobs_queued = 0;
  int unsigned jobs_taken = 0;
  int unsigned err_cnt = 0;

  int unsigned gap_max = 0;
  int unsigned stall_pct = 0;
  logic        hold_arm = 1'b0;

  logic [ModeW-1:0] pol_mode = PolRoundRobin;
  logic [CntW-1:0]  srv_count = 5'd1;
  logic [SrvW-1:0]  next_srv = 5'd1;
  logic             sweep_back = 1'b0;
  logic [WValW-1:0] rem_wt[MaxServersDef];
  logic [WValW-1:0] orig_wt[MaxServersDef];

  initial begin
    for (int i = 0; i < MaxServersDef; i++) begin
      rem_wt[i] = 8'd1;
      orig_wt[i] = 8'd1;
    end
  end

  function automatic void pick_server(input job_t j);
    int unsigned n;
    logic [SrvW-1:0] cur;
    logic [WValW-1:0] w;
    if (j.op == OpLoad) begin
      orig_wt[j.widx] = (j.wval == 0) ? 8'd1 : j.wval;
      rem_wt[j.widx] = (j.wval == 0) ? 8'd1 : j.wval;
      return;
    end
    if (!(pol_mode == PolRoundRobin || pol_mode == PolSweep ||
          pol_mode == PolOddEven || pol_mode == PolWeighted)) return;
    n = (srv_count == 0) ? 1 : (srv_count > MaxServersDef) ? MaxServersDef : srv_count;
    if (next_srv == 0 || next_srv > n) next_srv = 5'd1;
    cur = next_srv;
    case (pol_mode)
      PolRoundRobin: begin
        next_srv = (cur + 1 > n) ? 5'd1 : cur + 5'd1;
      end
      PolSweep: begin
        if (!sweep_back) begin
          if (cur + 1 > n) begin
            next_srv = (n >= 2) ? SrvW'(n - 1) : 5'd1;
            sweep_back = 1'b1;
          end else begin
            next_srv = cur + 5'd1;
          end
        end else begin
          if (cur <= 1) begin
            next_srv = (n >= 2) ? 5'd2 : 5'd1;
            sweep_back = 1'b0;
          end else begin
            next_srv = cur - 5'd1;
          end
        end
      end
      PolOddEven: begin
        if (n > 1) begin
          if (cur + 2 > n) begin
            next_srv = sweep_back ? 5'd1 : 5'd2;
            sweep_back = ~sweep_back;
          end else begin
            next_srv = cur + 5'd2;
          end
        end
      end
      default: begin
        w = rem_wt[cur - 1];
        w = (w == 0) ? 8'd0 : w - 8'd1;
        if (w == 0) begin
          w = orig_wt[cur - 1];
          next_srv = (cur + 1 > n) ? 5'd1 : cur + 5'd1;
        end
        rem_wt[cur - 1] = w;
      end
    endcase
    assignments_q.push_back('{server: cur, tag: j.tag});
  endfunction

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pick_server(cur_job);
        jobs_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || job_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_job = job_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_job.op;
          s_axis_tdata <= {4'b0, cur_job.wval, cur_job.widx, cur_job.tag};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    assignment_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (assignments_q.size() == 0) begin
        $error("unexpected beat: server_number %0d, tag_out %0h",
               m_axis_tdata[4:0], m_axis_tdata[20:5]);
        err_cnt++;
      end else begin
        want = assignments_q.pop_front();
        if (m_axis_tdata[4:0] !== want.server) begin
          $error("server_number: expected %0d, got %0d", want.server, m_axis_tdata[4:0]);
          err_cnt++;
        end
        if (m_axis_tdata[20:5] !== want.tag) begin
          $error("tag_out: expected %0h, got %0h", want.tag, m_axis_tdata[20:5]);
          err_cnt++;
        end
      end
    end
  end

  task automatic write_reg(input reg_e idx, input logic [RegW-1:0] val);
    logic [RegW-1:0] got;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == RegPolicy) pol_mode = val[ModeW-1:0];
    else srv_count = val[CntW-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== val) begin
      $error("register %0d readback: expected %0h, got %0h", idx, val, got);
      err_cnt++;
    end
  endtask

  task automatic set_mode(input logic [ModeW-1:0] pol, input logic [CntW-1:0] cnt);
    write_reg(RegPolicy, RegW'(pol));
    write_reg(RegCount, RegW'(cnt));
  endtask

  function automatic void add_request(input logic [TagW-1:0] tag);
    job_q.push_back('{op: OpRequest, tag: tag, widx: '0, wval: '0});
    jobs_queued++;
  endfunction

  function automatic void add_load(input logic [WIdxW-1:0] widx, input logic [WValW-1:0] wval);
    job_q.push_back('{op: OpLoad, tag: TagW'($urandom), widx: widx, wval: wval});
    jobs_queued++;
  endfunction

  task automatic drain;
    while (jobs_taken != jobs_queued || assignments_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned live;
    int unsigned len;
    int unsigned phase_no;
    int unsigned r;
    logic [ModeW-1:0] pol;
    logic [CntW-1:0] cnt;
    logic [WValW-1:0] wv;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    set_mode(PolRoundRobin, 5'd4);
    add_request(16'h0000);
    add_request(16'hFFFF);
    add_request(16'h1234);
    add_request(16'h8001);
    drain();
    set_mode(PolSweep, 5'd3);
    for (int i = 0; i < 4; i++) add_request(TagW'($urandom));
    drain();
    set_mode(PolOddEven, 5'd5);
    for (int i = 0; i < 4; i++) add_request(TagW'($urandom));
    drain();
    set_mode(PolWeighted, 5'd2);
    add_load(4'd0, 8'd0);
    add_load(4'd1, 8'd3);
    add_load(4'd15, 8'd255);
    for (int i = 0; i < 5; i++) add_request(TagW'($urandom));
    drain();
    set_mode(3'd0, 5'd0);
    add_request(16'hDEAD);
    add_load(4'd1, 8'd1);
    drain();
    set_mode(3'd7, 5'd31);
    add_request(16'hBEEF);
    drain();
    set_mode(PolRoundRobin, 5'd31);
    add_request(16'h5A5A);
    add_request(16'hA5A5);
    drain();

    live = 0;
    phase_no = 0;
    while (live < 850) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        r = $urandom_range(0, 3);
        pol = (r == 0) ? 3'd0 : ModeW'(r + 4);
      end else begin
        pol = ModeW'($urandom_range(1, 4));
      end
      r = $urandom_range(0, 9);
      case (r)
        0:       cnt = 5'd0;
        1:       cnt = CntW'($urandom_range(17, 31));
        2:       cnt = 5'd16;
        3:       cnt = 5'd1;
        default: cnt = CntW'($urandom_range(2, 15));
      endcase
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      len = $urandom_range(10, 50);
      if (phase_no == 5) begin
        pol = PolWeighted;
        cnt = 5'd6;
        len = 80;
        gap_max = 0;
        hold_arm <= 1'b1;
      end
      set_mode(pol, cnt);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < ((pol == PolWeighted) ? 20 : 8)) begin
          r = $urandom_range(0, 9);
          case (r)
            0:       wv = 8'd0;
            1:       wv = 8'd255;
            2:       wv = WValW'($urandom);
            default: wv = WValW'($urandom_range(1, 4));
          endcase
          add_load(WIdxW'($urandom), wv);
          live++;
        end else begin
          add_request(TagW'($urandom));
          if (pol >= 1 && pol <= 4) live++;
        end
      end
      drain();
      phase_no++;
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** server_selection_scheduler: PASSED **");
    end else begin
      $display("** server_selection_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("** server_selection_scheduler: FAILED **");
    $finish;
  end

endmodule
